FILE: sv/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg: shared constants and types for the disparity to point projector
// Register indexes, field widths and the pipeline stage records.
// ----------------------------------------------------------------------------
package dpp_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 1024;

    // field widths
    localparam int DISP_W  = 16;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 10;
    localparam int CH_W    = 8;
    localparam int LIM_W   = 24;
    localparam int SCALE_W = 16;
    localparam int INTR_W  = 16;
    localparam int COORD_W = 32;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // internal widths
    localparam int S_W    = 41;  // scaled disparity, Q8.32
    localparam int REM_W  = 42;  // depth divider partial remainder
    localparam int ZQ_W   = 33;  // depth quotient incl. overflow bit
    localparam int ZDIV_N = 33;  // depth divider stages
    localparam int OFF_W  = 18;  // signed pixel offset, Q.4
    localparam int MAG_W  = 17;  // offset magnitude
    localparam int PROD_W = 49;  // magnitude * depth
    localparam int FREM_W = 17;  // axis divider partial remainder
    localparam int ADIV_N = 32;  // axis divider stages

    // register indexes
    localparam logic [IDX_W-1:0] REG_MIN_DISP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_DISP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FOCAL_X   = 3'd5;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y   = 3'd6;
    localparam logic [IDX_W-1:0] REG_COLOR_EN  = 3'd7;

    // data riding along the depth divider
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_x;
        logic               neg_y;
        logic [MAG_W-1:0]   mag_y;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [S_W-1:0]   s;
        logic [ZQ_W-1:0]  q;
        logic             zsat;
        side_t            side;
    } zdiv_t;

    typedef struct packed {
        logic               neg_x;
        logic [PROD_W-1:0]  prod_x;
        logic               neg_y;
        logic [PROD_W-1:0]  prod_y;
        logic [COORD_W-1:0] z;
        logic               inv;
        logic [COLOR_W-1:0] color;
    } mul_t;

    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic [FREM_W-1:0]  rem;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] q;
    } axis_t;

    typedef struct packed {
        axis_t              ax;
        axis_t              ay;
        logic [COORD_W-1:0] z;
        logic               inv;
        logic [COLOR_W-1:0] color;
    } pt_t;

endpackage

FILE: sv/disparity_to_point_projector.sv
// ----------------------------------------------------------------------------
// disparity_to_point_projector: pixel disparity to 3-D point, pipelined
// Scales the disparity, divides for depth and back-projects x and y.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall carry one pixel request (disparity,
//   column, row, red, green, blue). Output channel: out_valid / out_stall
//   carry one point (point_x, point_y, point_z, packed_color, depth_invalid).
//   A request moves when valid is high and stall is low.
//   One pixel per cycle is taken and delivered while the output is not stalled.
//   The pipeline holds two bit-per-stage dividers: 33 stages for the
//   depth reciprocal and 32 for the pinhole division, plus the entry, depth
//   set-up, multiply, range-check and output stages.
//   The pipeline advances as one: while a result waits in the output
//   register under out_stall, every stage holds and in_stall is raised;
//   nothing is lost or repeated. Empty stages travel as bubbles.
//   Reset clears all valid bits and loads the register defaults.
//   The user must write configuration (cfg_write, cfg_index, cfg_data) only
//   while the pipeline is empty (not enforced); stages read registers directly.
// ----------------------------------------------------------------------------
module disparity_to_point_projector
    import dpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [DISP_W-1:0]         disparity,
    input  logic [COL_W-1:0]          column,
    input  logic [ROW_W-1:0]          row,
    input  logic [CH_W-1:0]           red,
    input  logic [CH_W-1:0]           green,
    input  logic [CH_W-1:0]           blue,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic [COORD_W-1:0]        point_z,
    output logic [COLOR_W-1:0]        packed_color,
    output logic                      depth_invalid
);

    // configuration registers
    logic [LIM_W-1:0]   min_disp_reg;
    logic [LIM_W-1:0]   max_disp_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [INTR_W-1:0]  center_x_reg;
    logic [INTR_W-1:0]  center_y_reg;
    logic [INTR_W-1:0]  focal_x_reg;
    logic [INTR_W-1:0]  focal_y_reg;
    logic               color_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_disp_reg <= LIM_W'(655);
            max_disp_reg <= LIM_W'(655360);
            scale_reg    <= SCALE_W'(256);
            center_x_reg <= '0;
            center_y_reg <= '0;
            focal_x_reg  <= INTR_W'(16);
            focal_y_reg  <= INTR_W'(16);
            color_en_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_DISP: min_disp_reg <= cfg_data;
                REG_MAX_DISP: max_disp_reg <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_CENTER_X: center_x_reg <= cfg_data[INTR_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[INTR_W-1:0];
                REG_FOCAL_X:  focal_x_reg  <= cfg_data[INTR_W-1:0];
                REG_FOCAL_Y:  focal_y_reg  <= cfg_data[INTR_W-1:0];
                REG_COLOR_EN: color_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output holds a stalled result
    logic out_valid_reg;
    logic adv;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // entry: clamp pixel, offsets, colour, disparity product
    logic [COL_W-1:0]          col_c;
    logic [ROW_W-1:0]          row_c;
    logic signed [OFF_W-1:0]   off_x;
    logic signed [OFF_W-1:0]   off_y;
    logic signed [LIM_W:0]     diff;
    logic signed [LIM_W+DISP_W+1:0] prod_next;
    side_t                     side_next;

    always_comb
    begin
        col_c = (32'(column) >= 32'(MAX_WIDTH))  ? COL_W'(MAX_WIDTH - 1)  : column;
        row_c = (32'(row)    >= 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1) : row;
        off_x = signed'(OFF_W'({col_c, 4'b0000})) - signed'(OFF_W'(center_x_reg));
        off_y = signed'(OFF_W'({row_c, 4'b0000})) - signed'(OFF_W'(center_y_reg));
        diff  = signed'({1'b0, max_disp_reg}) - signed'({1'b0, min_disp_reg});
        prod_next = diff * signed'({1'b0, disparity});
        side_next.color = color_en_reg ? {red, green, blue} : '0;
        side_next.neg_x = off_x[OFF_W-1];
        side_next.mag_x = off_x[OFF_W-1] ? MAG_W'(-off_x) : MAG_W'(off_x);
        side_next.neg_y = off_y[OFF_W-1];
        side_next.mag_y = off_y[OFF_W-1] ? MAG_W'(-off_y) : MAG_W'(off_y);
    end

    logic                            v1_reg;
    logic signed [LIM_W+DISP_W+1:0]  prod1_reg;
    side_t                           side1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg <= prod_next;
            side1_reg <= side_next;
        end
    end

    // scaled disparity and depth overflow check
    logic signed [LIM_W+DISP_W+1:0] s_full;
    logic [SCALE_W+6:0]             num0;
    zdiv_t                          zd0_next;

    always_comb
    begin
        s_full = signed'({2'b00, min_disp_reg, 16'h0000}) + prod1_reg;
        num0   = {scale_reg, 7'b0000000};
        zd0_next.s    = s_full[S_W-1:0];
        zd0_next.rem  = REM_W'(num0);
        zd0_next.q    = '0;
        zd0_next.zsat = (S_W'(num0) >= s_full[S_W-1:0]);
        zd0_next.side = side1_reg;
    end

    // depth divider, one quotient bit per stage
    logic [ZDIV_N:0] vz_reg;
    zdiv_t           zd_reg [ZDIV_N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vz_reg <= '0;
        else if (adv)
            vz_reg <= {vz_reg[ZDIV_N-1:0], v1_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            zd_reg[0] <= zd0_next;
    end

    genvar k;
    generate
        for (k = 0; k < ZDIV_N; k++)
        begin : g_zdiv
            logic [REM_W-1:0] t;
            logic             ge;
            zdiv_t            nxt;
            always_comb
            begin
                t   = {zd_reg[k].rem[REM_W-2:0], 1'b0};
                ge  = (t >= REM_W'(zd_reg[k].s));
                nxt = zd_reg[k];
                nxt.rem = ge ? (t - REM_W'(zd_reg[k].s)) : t;
                nxt.q   = {zd_reg[k].q[ZQ_W-2:0], ge};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    zd_reg[k+1] <= nxt;
            end
        end
    endgenerate

    // depth saturation and the offset * depth products
    logic [COORD_W-1:0] z_val;
    logic               z_inv;
    mul_t               mul_next;

    always_comb
    begin
        z_inv = zd_reg[ZDIV_N].zsat || zd_reg[ZDIV_N].q[ZQ_W-1];
        z_val = z_inv ? '1 : zd_reg[ZDIV_N].q[COORD_W-1:0];
        mul_next.neg_x  = zd_reg[ZDIV_N].side.neg_x;
        mul_next.prod_x = PROD_W'(zd_reg[ZDIV_N].side.mag_x) * PROD_W'(z_val);
        mul_next.neg_y  = zd_reg[ZDIV_N].side.neg_y;
        mul_next.prod_y = PROD_W'(zd_reg[ZDIV_N].side.mag_y) * PROD_W'(z_val);
        mul_next.z      = z_val;
        mul_next.inv    = z_inv;
        mul_next.color  = zd_reg[ZDIV_N].side.color;
    end

    logic vm_reg;
    mul_t mul_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (adv)
            vm_reg <= vz_reg[ZDIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            mul_reg <= mul_next;
    end

    // focal length, zero taken as one
    logic [INTR_W-1:0] fx;
    logic [INTR_W-1:0] fy;
    assign fx = (focal_x_reg == '0) ? INTR_W'(1) : focal_x_reg;
    assign fy = (focal_y_reg == '0) ? INTR_W'(1) : focal_y_reg;

    // axis divider set-up: range check and first remainder
    pt_t pt0_next;

    always_comb
    begin
        pt0_next.ax.neg = mul_reg.neg_x;
        pt0_next.ax.ovf = (mul_reg.prod_x >= {1'b0, fx, 32'h0});
        pt0_next.ax.rem = mul_reg.prod_x[PROD_W-1:COORD_W];
        pt0_next.ax.low = mul_reg.prod_x[COORD_W-1:0];
        pt0_next.ax.q   = '0;
        pt0_next.ay.neg = mul_reg.neg_y;
        pt0_next.ay.ovf = (mul_reg.prod_y >= {1'b0, fy, 32'h0});
        pt0_next.ay.rem = mul_reg.prod_y[PROD_W-1:COORD_W];
        pt0_next.ay.low = mul_reg.prod_y[COORD_W-1:0];
        pt0_next.ay.q   = '0;
        pt0_next.z      = mul_reg.z;
        pt0_next.inv    = mul_reg.inv;
        pt0_next.color  = mul_reg.color;
    end

    logic [ADIV_N:0] vp_reg;
    pt_t             pd_reg [ADIV_N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= '0;
        else if (adv)
            vp_reg <= {vp_reg[ADIV_N-1:0], vm_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pd_reg[0] <= pt0_next;
    end

    // pinhole dividers for x and y, one bit per stage
    genvar j;
    generate
        for (j = 0; j < ADIV_N; j++)
        begin : g_adiv
            logic [FREM_W-1:0] tx;
            logic [FREM_W-1:0] ty;
            logic              gx;
            logic              gy;
            pt_t               nxt;
            always_comb
            begin
                tx  = {pd_reg[j].ax.rem[FREM_W-2:0], pd_reg[j].ax.low[COORD_W-1]};
                ty  = {pd_reg[j].ay.rem[FREM_W-2:0], pd_reg[j].ay.low[COORD_W-1]};
                gx  = (tx >= FREM_W'(fx));
                gy  = (ty >= FREM_W'(fy));
                nxt = pd_reg[j];
                nxt.ax.rem = gx ? (tx - FREM_W'(fx)) : tx;
                nxt.ax.low = {pd_reg[j].ax.low[COORD_W-2:0], 1'b0};
                nxt.ax.q   = {pd_reg[j].ax.q[COORD_W-2:0], gx};
                nxt.ay.rem = gy ? (ty - FREM_W'(fy)) : ty;
                nxt.ay.low = {pd_reg[j].ay.low[COORD_W-2:0], 1'b0};
                nxt.ay.q   = {pd_reg[j].ay.q[COORD_W-2:0], gy};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                    pd_reg[j+1] <= nxt;
            end
        end
    endgenerate

    // sign and signed saturation
    function automatic logic [COORD_W-1:0] axis_out(input axis_t a);
        logic [COORD_W-1:0] r;
        if (a.neg)
            r = (a.ovf || a.q[COORD_W-1]) ? 32'h8000_0000 : (~a.q + 32'd1);
        else
            r = (a.ovf || a.q[COORD_W-1]) ? 32'h7FFF_FFFF : a.q;
        return r;
    endfunction

    logic [COORD_W-1:0] px_next;
    logic [COORD_W-1:0] py_next;
    assign px_next = axis_out(pd_reg[ADIV_N].ax);
    assign py_next = axis_out(pd_reg[ADIV_N].ay);

    // output register
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic [COORD_W-1:0] pz_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vp_reg[ADIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pz_reg    <= pd_reg[ADIV_N].z;
            color_reg <= pd_reg[ADIV_N].color;
            inv_reg   <= pd_reg[ADIV_N].inv;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = signed'(px_reg);
    assign point_y       = signed'(py_reg);
    assign point_z       = pz_reg;
    assign packed_color  = color_reg;
    assign depth_invalid = inv_reg;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the disparity to point projector
// Drives random and directed pixel requests with random gaps and stalls,
// predicts each point from the register settings and checks every result.
// ----------------------------------------------------------------------------
module tb_top
    import dpp_pkg::*;
();

    typedef struct packed {
        logic [DISP_W-1:0] disp;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  rw;
        logic [CH_W-1:0]   r;
        logic [CH_W-1:0]   g;
        logic [CH_W-1:0]   b;
    } pixel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [COORD_W-1:0]        pz;
        logic [COLOR_W-1:0]        col;
        logic                      inv;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [DISP_W-1:0] disparity = '0;
    logic [COL_W-1:0] column = '0;
    logic [ROW_W-1:0] row = '0;
    logic [CH_W-1:0] red = '0;
    logic [CH_W-1:0] green = '0;
    logic [CH_W-1:0] blue = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_z;
    logic [COLOR_W-1:0] packed_color;
    logic depth_invalid;

    // local copy of the register file
    logic [LIM_W-1:0] m_min, m_max;
    logic [SCALE_W-1:0] m_scale;
    logic [INTR_W-1:0] m_cx, m_cy, m_fx, m_fy;
    logic m_colen;

    pixel_t pending_px[$];
    point_t expected_pts[$];
    int errors = 0;
    longint cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    // in_stall as seen at the last rising edge, so that acceptance is known
    logic in_stall_q = 1'b1;

    disparity_to_point_projector u_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pinhole back-projection of one axis, truncated and saturated
    function automatic logic signed [31:0] back_project(longint pix, longint ctr,
                                                        longint foc, longint z);
        longint q;
        q = ((pix * 16) - ctr) * z / ((foc == 0) ? 1 : foc);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic point_t project_pixel(pixel_t p);
        point_t e;
        longint s;
        logic [63:0] z;
        s = longint'(m_min) * 65536 + (longint'(m_max) - longint'(m_min)) * longint'(p.disp);
        e.inv = 1'b0;
        if (s <= 0)
        begin
            z = 64'hFFFF_FFFF;
            e.inv = 1'b1;
        end
        else
        begin
            z = (64'(m_scale) << 40) / 64'(s);
            if (z > 64'hFFFF_FFFF)
            begin
                z = 64'hFFFF_FFFF;
                e.inv = 1'b1;
            end
        end
        e.px = back_project(longint'(p.col), longint'(m_cx), longint'(m_fx), longint'(z));
        e.py = back_project(longint'(p.rw), longint'(m_cy), longint'(m_fy), longint'(z));
        e.pz = z[31:0];
        e.col = m_colen ? {p.r, p.g, p.b} : '0;
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // append to the request and expected-point queues
    task automatic queue_pixel(pixel_t p);
        pending_px.insert(pending_px.size(), p);
    endtask

    task automatic store_point(point_t e);
        expected_pts.insert(expected_pts.size(), e);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_MIN_DISP: m_min = val;
            REG_MAX_DISP: m_max = val;
            REG_SCALE:    m_scale = val[SCALE_W-1:0];
            REG_CENTER_X: m_cx = val[INTR_W-1:0];
            REG_CENTER_Y: m_cy = val[INTR_W-1:0];
            REG_FOCAL_X:  m_fx = val[INTR_W-1:0];
            REG_FOCAL_Y:  m_fy = val[INTR_W-1:0];
            REG_COLOR_EN: m_colen = val[0];
            default:      ;
        endcase
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        logic [63:0] w;
        w = {$urandom, $urandom};
        p = w[$bits(pixel_t)-1:0];
        case ($urandom_range(0, 7))
            0: p.disp = 16'h0000;
            1: p.disp = 16'hFFFF;
            default: ;
        endcase
        return p;
    endfunction

    // drain the pipeline before touching registers
    task automatic wait_idle();
        while (pending_px.size() != 0 || expected_pts.size() != 0 || in_valid)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // request driver: after acceptance draw a gap, then present the next request
    always @(negedge clk)
    begin
        logic   slot_free;
        pixel_t p;
        if (rst_n)
        begin
            slot_free = !in_valid;
            if (in_valid && !in_stall_q)
            begin
                slot_free = 1'b1;
                in_gap = $urandom_range(0, 5);
            end
            if (slot_free)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_px.size() != 0)
                begin
                    p = pending_px.pop_front();
                    {disparity, column, row, red, green, blue} <= p;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
        if (in_valid && !in_stall)
            store_point(project_pixel(pixel_t'({disparity, column, row,
                                                red, green, blue})));
    end

    // result monitor; each accepted point draws the receiver's next wait
    always @(posedge clk)
    begin
        cycles++;
        if (out_valid && !out_stall)
        begin
            point_t e;
            out_gap = $urandom_range(0, 5);
            if (expected_pts.size() == 0)
                report_mismatch("unexpected point", 64'd0, 64'd0);
            else
            begin
                e = expected_pts.pop_front();
                if (point_x !== e.px) report_mismatch("point_x", point_x, e.px);
                if (point_y !== e.py) report_mismatch("point_y", point_y, e.py);
                if (point_z !== e.pz) report_mismatch("point_z", point_z, e.pz);
                if (packed_color !== e.col) report_mismatch("color", packed_color, e.col);
                if (depth_invalid !== e.inv) report_mismatch("invalid", depth_invalid, e.inv);
            end
        end
        if (cycles > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        m_min = 24'd655;
        m_max = 24'd655360;
        m_scale = 16'd256;
        m_cx = '0;
        m_cy = '0;
        m_fx = 16'd16;
        m_fy = 16'd16;
        m_colen = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and the special cases under reset settings
        queue_pixel(pixel_t'{16'h0000, 11'd0, 10'd0, 8'h00, 8'h00, 8'h00});
        queue_pixel(pixel_t'{16'hFFFF, 11'd2047, 10'd1023, 8'hFF, 8'hFF, 8'hFF});
        queue_pixel(pixel_t'{16'h8000, 11'd1024, 10'd512, 8'hA5, 8'h5A, 8'h3C});
        queue_pixel(pixel_t'{16'h0001, 11'd1, 10'd1, 8'h01, 8'h80, 8'h7F});
        wait_idle();

        // zero scaled disparity, zero focal, colour disabled, maximum centre values
        write_reg(REG_MIN_DISP, 24'd0);
        write_reg(REG_FOCAL_X, 24'd0);
        write_reg(REG_FOCAL_Y, 24'd0);
        write_reg(REG_COLOR_EN, 24'd0);
        write_reg(REG_CENTER_X, 24'hFFFF);
        write_reg(REG_CENTER_Y, 24'hFFFF);
        queue_pixel(pixel_t'{16'h0000, 11'd0, 10'd0, 8'hFF, 8'hFF, 8'hFF});
        queue_pixel(pixel_t'{16'hFFFF, 11'd2047, 10'd1023, 8'h12, 8'h34, 8'h56});
        queue_pixel(pixel_t'{16'h0001, 11'd5, 10'd7, 8'h00, 8'hFF, 8'h00});
        wait_idle();

        // reversed limits and depth saturation
        write_reg(REG_MIN_DISP, 24'hFFFFFF);
        write_reg(REG_MAX_DISP, 24'd0);
        write_reg(REG_SCALE, 24'hFFFF);
        write_reg(REG_COLOR_EN, 24'd1);
        write_reg(REG_FOCAL_X, 24'hFFFF);
        write_reg(REG_FOCAL_Y, 24'd1);
        write_reg(REG_CENTER_X, 24'd0);
        write_reg(REG_CENTER_Y, 24'd0);
        queue_pixel(pixel_t'{16'hFFFF, 11'd2047, 10'd1023, 8'h11, 8'h22, 8'h33});
        queue_pixel(pixel_t'{16'h0000, 11'd0, 10'd0, 8'h44, 8'h55, 8'h66});
        queue_pixel(pixel_t'{16'hFFFE, 11'd100, 10'd900, 8'h77, 8'h88, 8'h99});
        wait_idle();

        // zero depth scale
        write_reg(REG_SCALE, 24'd0);
        queue_pixel(pixel_t'{16'h1234, 11'd300, 10'd200, 8'h01, 8'h02, 8'h03});
        wait_idle();

        // random phases with random settings
        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(REG_MIN_DISP, (ph == 0) ? 24'd0 : 24'($urandom));
            write_reg(REG_MAX_DISP, (ph == 1) ? 24'hFFFFFF : 24'($urandom));
            write_reg(REG_SCALE, (ph == 2) ? 24'hFFFF : 24'($urandom_range(0, 65535)));
            write_reg(REG_CENTER_X, 24'($urandom_range(0, 65535)));
            write_reg(REG_CENTER_Y, 24'($urandom_range(0, 65535)));
            write_reg(REG_FOCAL_X, 24'($urandom_range(1, 65535)));
            write_reg(REG_FOCAL_Y, (ph == 3) ? 24'd1 : 24'($urandom_range(1, 65535)));
            write_reg(REG_COLOR_EN, 24'($urandom_range(0, 1)));
            for (int i = 0; i < 150; i++)
                queue_pixel(rand_pixel());
            wait_idle();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
